// ===== rtl/dsv_pkg.sv =====
package dsv_pkg;

  // Default build parameters
  localparam int DEF_SENSORS   = 12;
  localparam int DEF_SAMPLES   = 8;
  localparam int DEF_DIST_BITS = 10;

  // Fixed field widths
  localparam int SENSOR_W   = 4;
  localparam int DIST_W     = 10;
  localparam int MINS_W     = 4;
  localparam int TOL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_MIN_SAMPLES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_REL_TOLERANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_MIN_SAMPLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_REL_TOLERANCE = 3'd4;

  // Register reset values
  localparam int RESET_MAX_DIST = 400;
  localparam logic [DIST_W-1:0] RST_MAX_DISTANCE       = 10'd400;
  localparam logic [MINS_W-1:0] RST_FAR_MIN_SAMPLES    = 4'd2;
  localparam logic [TOL_W-1:0]  RST_FAR_REL_TOLERANCE  = 8'd13;
  localparam logic [MINS_W-1:0] RST_NEAR_MIN_SAMPLES   = 4'd4;
  localparam logic [TOL_W-1:0]  RST_NEAR_REL_TOLERANCE = 8'd26;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_WALK,
    ST_FIN
  } dsv_state_t;

endpackage

// ===== rtl/dsv_reading_if.sv =====
interface dsv_reading_if;
  import dsv_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_number;
  logic [DIST_W-1:0]   raw_distance;

  modport source (output valid, output sensor_number, output raw_distance, input ready);
  modport sink   (input valid, input sensor_number, input raw_distance, output ready);
endinterface

// ===== rtl/dsv_result_if.sv =====
interface dsv_result_if;
  import dsv_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_out;
  logic [DIST_W-1:0]   accepted_distance;
  logic                took_new;

  modport source (output valid, output sensor_out, output accepted_distance,
                  output took_new, input ready);
  modport sink   (input valid, input sensor_out, input accepted_distance,
                  input took_new, output ready);
endinterface

// ===== rtl/distance_sample_validator_unit.sv =====
// Steps: an in-range item passes ST_FIRST, which writes the reading to its ring slot and
// checks it against the last accepted one; ST_WALK over k <= SAMPLES-1 older samples if
// that check fails and more than one is needed; ST_FIN, which loads the output register.
// Throughput: one item at a time; the next item is taken once the result is in the output
// register. The walk reads one ring entry per cycle through the ring's single read port.
// Reset (synchronous, rst high): registers to their defaults, every sensor's history reads
// as 400 through per-sensor fill counts, so there is no clearing pass.
module distance_sample_validator_unit #(
  parameter int SENSORS   = dsv_pkg::DEF_SENSORS,
  parameter int SAMPLES   = dsv_pkg::DEF_SAMPLES,
  parameter int DIST_BITS = dsv_pkg::DEF_DIST_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsv_pkg::CFG_DATA_W-1:0] cfg_data,
  dsv_reading_if.sink                   reading,
  dsv_result_if.source                  result
);
  import dsv_pkg::*;

  localparam int SIDX_W     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SLOT_W     = $clog2(SAMPLES);
  localparam int FILL_W     = $clog2(SAMPLES + 1);
  localparam int RING_DEPTH = SENSORS * SAMPLES;
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PROD_W     = DIST_BITS + TOL_W;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  localparam dist_t RESET_DIST = DIST_BITS'(RESET_MAX_DIST);
  localparam slot_t LAST_SLOT  = SLOT_W'(SAMPLES - 1);

  // |v - r| * 256 <= limit, limit = r * tol
  function automatic logic tol_ok(input dist_t v, input dist_t r,
                                  input logic [PROD_W-1:0] limit);
    dist_t diff;
    diff = (v >= r) ? (v - r) : (r - v);
    return {diff, 8'd0} <= limit;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic slot_t slot_dec(input slot_t s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SIDX_W-1:0] s,
                                                  input slot_t k);
    return ADDR_W'(32'(s) * SAMPLES + 32'(k));
  endfunction

  // Configuration registers
  logic [DIST_W-1:0] max_distance;
  logic [MINS_W-1:0] far_min_samples;
  logic [TOL_W-1:0]  far_rel_tolerance;
  logic [MINS_W-1:0] near_min_samples;
  logic [TOL_W-1:0]  near_rel_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance       <= RST_MAX_DISTANCE;
      far_min_samples    <= RST_FAR_MIN_SAMPLES;
      far_rel_tolerance  <= RST_FAR_REL_TOLERANCE;
      near_min_samples   <= RST_NEAR_MIN_SAMPLES;
      near_rel_tolerance <= RST_NEAR_REL_TOLERANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DISTANCE:       max_distance       <= cfg_data;
        REG_FAR_MIN_SAMPLES:    far_min_samples    <= cfg_data[MINS_W-1:0];
        REG_FAR_REL_TOLERANCE:  far_rel_tolerance  <= cfg_data[TOL_W-1:0];
        REG_NEAR_MIN_SAMPLES:   near_min_samples   <= cfg_data[MINS_W-1:0];
        REG_NEAR_REL_TOLERANCE: near_rel_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sensor state
  dist_t             last_accepted [SENSORS];
  slot_t             write_slot    [SENSORS];
  logic [FILL_W-1:0] fill          [SENSORS];

  // Sample ring memory
  dist_t             ring [RING_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  dist_t             rd_data;

  // Item registers
  dsv_state_t          state, state_next;
  logic [SENSOR_W-1:0] sensor;
  logic                oor;
  dist_t               meas;
  slot_t               slot;
  slot_t               rd_idx;
  logic [FILL_W-1:0]   count;
  logic [MINS_W-1:0]   minn;
  logic [PROD_W-1:0]   walk_prod;
  logic                take;

  logic                out_valid;
  logic [SENSOR_W-1:0] out_sensor;
  logic [DIST_W-1:0]   out_dist;
  logic                out_took;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= meas;
    end
    rd_data <= ring[mem_raddr];
  end

  // Shared decode
  logic [SIDX_W-1:0] sidx;
  dist_t             maxd;
  dist_t             prev;
  slot_t             ws_next;
  logic              far;
  logic [MINS_W-1:0] minn_sel;
  logic [TOL_W-1:0]  tol_sel;
  logic              first_ok;
  dist_t             sample;
  logic              match;
  logic [FILL_W-1:0] count_inc;
  logic              in_acc;
  logic              out_load;

  assign sidx      = sensor[SIDX_W-1:0];
  assign maxd      = DIST_BITS'(max_distance);
  assign prev      = last_accepted[sidx];
  assign ws_next   = slot_inc(write_slot[sidx]);
  assign far       = (meas == maxd);
  assign minn_sel  = far ? far_min_samples : near_min_samples;
  assign tol_sel   = far ? far_rel_tolerance : near_rel_tolerance;
  assign first_ok  = tol_ok(meas, prev, PROD_W'(prev) * PROD_W'(tol_sel));
  assign sample    = (FILL_W'(rd_idx) < fill[sidx]) ? rd_data : RESET_DIST;
  assign match     = tol_ok(sample, meas, walk_prod);
  assign count_inc = count + 1'b1;
  assign in_acc    = reading.valid && reading.ready;
  assign out_load  = (state == ST_FIN) && (!out_valid || result.ready);

  // Walk decisions
  logic walk_hit;
  logic walk_end;
  assign walk_hit = match && (32'(count_inc) + 1 >= 32'(minn));
  assign walk_end = !match || walk_hit || (slot_dec(rd_idx) == slot);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (32'(reading.sensor_number) >= SENSORS) ? ST_FIN : ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_next = (first_ok || minn_sel <= 4'd1) ? ST_FIN : ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    mem_we    = (state == ST_FIRST);
    mem_waddr = ring_addr(sidx, ws_next);
    if (state == ST_FIRST) begin
      mem_raddr = ring_addr(sidx, slot_dec(ws_next));
    end else begin
      mem_raddr = ring_addr(sidx, slot_dec(rd_idx));
    end
  end

  assign reading.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          sensor <= reading.sensor_number;
          oor    <= (32'(reading.sensor_number) >= SENSORS);
          meas   <= (reading.raw_distance != '0) ? DIST_BITS'(reading.raw_distance) : maxd;
          take   <= 1'b0;
        end
      end
      ST_FIRST: begin
        slot      <= ws_next;
        rd_idx    <= slot_dec(ws_next);
        count     <= '0;
        minn      <= minn_sel;
        walk_prod <= PROD_W'(meas) * PROD_W'(tol_sel);
        take      <= first_ok || (minn_sel <= 4'd1);
      end
      ST_WALK: begin
        if (match) begin
          count <= count_inc;
        end
        if (walk_end) begin
          take <= walk_hit || (32'(count) + 1 >= 32'(minn));
        end else begin
          rd_idx <= slot_dec(rd_idx);
        end
      end
      default: ;
    endcase
  end

  // Per-sensor state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSORS; s++) begin
        last_accepted[s] <= RESET_DIST;
        write_slot[s]    <= LAST_SLOT;
        fill[s]          <= '0;
      end
    end else begin
      if (state == ST_FIRST) begin
        write_slot[sidx] <= ws_next;
        if (32'(fill[sidx]) < SAMPLES) begin
          fill[sidx] <= fill[sidx] + 1'b1;
        end
      end
      if (out_load && !oor && take) begin
        last_accepted[sidx] <= meas;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sensor <= sensor;
      out_took   <= !oor && take;
      if (oor) begin
        out_dist <= '0;
      end else begin
        out_dist <= DIST_W'(take ? meas : prev);
      end
    end
  end

  assign result.valid             = out_valid;
  assign result.sensor_out        = out_sensor;
  assign result.accepted_distance = out_dist;
  assign result.took_new          = out_took;

`ifndef SYNTHESIS
  // An accepted item always takes the block out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != ST_IDLE)
    else $error("accepted item did not start work");

  // The walk never revisits the entry just written
  a_walk_skips_new: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> rd_idx != slot)
    else $error("walk reached the newly written slot");

  // The walk only runs for in-range sensors
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIRST || state == ST_WALK) |-> !oor)
    else $error("walk on out-of-range sensor");

  // A taken reading becomes the sensor's last accepted distance
  a_take_commits: assert property (@(posedge clk) disable iff (rst)
    (out_load && !oor && take) |=> last_accepted[$past(sidx)] == $past(meas))
    else $error("accepted reading not stored");
`endif

endmodule

// ===== tb/sv/tb_distance_sample_validator_unit.sv =====
module tb_distance_sample_validator_unit;
  import dsv_pkg::*;

  localparam int SENSORS   = DEF_SENSORS;
  localparam int SAMPLES   = DEF_SAMPLES;
  localparam int DIR_ROWS  = 23;
  localparam int SETTLE    = SAMPLES + 4;
  localparam int MAX_SENSOR_CODE = (1 << SENSOR_W) - 1;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [DIST_W-1:0]   dist_cm;
    logic                took;
  } distance_result_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [DIST_W-1:0]   raw;
    logic                typed;
    distance_result_t    want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dsv_reading_if reading_ch ();
  dsv_result_if  result_ch ();

  distance_sample_validator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .reading   (reading_ch),
    .result    (result_ch)
  );

  // Shadow copy of the block's settings and per-sensor history
  logic [DIST_W-1:0] cfg_max_distance;
  logic [MINS_W-1:0] cfg_far_min;
  logic [TOL_W-1:0]  cfg_far_tol;
  logic [MINS_W-1:0] cfg_near_min;
  logic [TOL_W-1:0]  cfg_near_tol;

  logic [DIST_W-1:0] history [SENSORS][SAMPLES];
  logic [DIST_W-1:0] last_good [SENSORS];
  int                newest_slot [SENSORS];

  distance_result_t expected_results[$];
  directed_row_t    directed_table [DIR_ROWS];
  int               sensor_target [16];
  int               focus_sensor;
  int               mismatches;
  bit               steady_run;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic bit in_tolerance(input int unsigned v, input int unsigned r,
                                      input int unsigned tol);
    int unsigned diff;
    diff = (v >= r) ? v - r : r - v;
    return diff * 256 <= r * tol;
  endfunction

  function automatic void clear_history();
    cfg_max_distance = RST_MAX_DISTANCE;
    cfg_far_min      = RST_FAR_MIN_SAMPLES;
    cfg_far_tol      = RST_FAR_REL_TOLERANCE;
    cfg_near_min     = RST_NEAR_MIN_SAMPLES;
    cfg_near_tol     = RST_NEAR_REL_TOLERANCE;
    for (int s = 0; s < SENSORS; s++) begin
      for (int k = 0; k < SAMPLES; k++) history[s][k] = RST_MAX_DISTANCE;
      last_good[s]   = RST_MAX_DISTANCE;
      newest_slot[s] = SAMPLES - 1;
    end
  endfunction

  // Validate one reading against the sensor's history and update it
  function automatic distance_result_t predict_validated_distance(
      input logic [SENSOR_W-1:0] sensor, input logic [DIST_W-1:0] raw);
    distance_result_t res;
    logic [DIST_W-1:0] meas;
    int slot, idx, minn, count;
    int unsigned tol;
    bit take, agreeing;
    res.sensor  = sensor;
    res.dist_cm = '0;
    res.took    = 1'b0;
    if (sensor >= SENSORS) return res;

    meas = (raw != '0) ? raw : cfg_max_distance;
    slot = (newest_slot[sensor] + 1) % SAMPLES;
    newest_slot[sensor] = slot;
    history[sensor][slot] = meas;

    // far readings use their own count and tolerance
    if (meas == cfg_max_distance) begin
      minn = cfg_far_min;
      tol  = cfg_far_tol;
    end else begin
      minn = cfg_near_min;
      tol  = cfg_near_tol;
    end

    if (in_tolerance(meas, last_good[sensor], tol)) begin
      take = 1'b1;
    end else begin
      // newest to oldest, stop at the first disagreeing sample
      count    = 0;
      agreeing = 1'b1;
      idx      = (slot + SAMPLES - 1) % SAMPLES;
      while (agreeing && idx != slot && count < minn) begin
        if (in_tolerance(history[sensor][idx], meas, tol)) begin
          count++;
          idx = (idx + SAMPLES - 1) % SAMPLES;
        end else begin
          agreeing = 1'b0;
        end
      end
      take = (minn == 0) || (count + 1 >= minn);
    end

    if (take) last_good[sensor] = meas;
    res.dist_cm = last_good[sensor];
    res.took    = take;
    return res;
  endfunction

  // Register write; the shadow copy follows at once since the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_MAX_DISTANCE:       cfg_max_distance = value[DIST_W-1:0];
      REG_FAR_MIN_SAMPLES:    cfg_far_min      = value[MINS_W-1:0];
      REG_FAR_REL_TOLERANCE:  cfg_far_tol      = value[TOL_W-1:0];
      REG_NEAR_MIN_SAMPLES:   cfg_near_min     = value[MINS_W-1:0];
      REG_NEAR_REL_TOLERANCE: cfg_near_tol     = value[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drive one item; entered and left at a falling edge
  task automatic send_reading(input logic [SENSOR_W-1:0] sensor,
                              input logic [DIST_W-1:0] raw,
                              input logic typed, input distance_result_t want);
    distance_result_t predicted;
    while (!steady_run && $urandom_range(0, 99) < 27) begin
      reading_ch.valid <= 1'b0;
      @(negedge clk);
    end
    reading_ch.valid         <= 1'b1;
    reading_ch.sensor_number <= sensor;
    reading_ch.raw_distance  <= raw;
    @(posedge clk);
    while (!reading_ch.ready) @(posedge clk);
    predicted = predict_validated_distance(sensor, raw);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Streaks on one sensor so the sample walk sees agreeing histories
  function automatic logic [SENSOR_W-1:0] pick_sensor();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return SENSOR_W'($urandom_range(SENSORS, MAX_SENSOR_CODE));
    if (roll < 15) return SENSOR_W'($urandom_range(0, SENSORS - 1));
    if ($urandom_range(0, 7) == 0) focus_sensor = $urandom_range(0, SENSORS - 1);
    return SENSOR_W'(focus_sensor);
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(input int sensor);
    int roll, span, d;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 18) return cfg_max_distance;
    if (roll < 26) return DIST_W'($urandom_range(0, 1023));
    if (roll < 30) begin
      case ($urandom_range(0, 3))
        0:       return 10'd1;
        1:       return 10'd1023;
        2:       return 10'd512;
        default: return 10'd511;
      endcase
    end
    if (roll < 36) sensor_target[sensor] = $urandom_range(1, 1023);
    // jitter around the sensor's current distance
    span = sensor_target[sensor] / 16 + 1;
    d = sensor_target[sensor] + $urandom_range(0, 2 * span) - span;
    if (d < 1) d = 1;
    if (d > 1023) d = 1023;
    return d[DIST_W-1:0];
  endfunction

  // One setting of the registers followed by random items, then drain
  task automatic run_phase(input bit write_cfg, input int maxd, input int far_min,
                           input int far_tol, input int near_min, input int near_tol,
                           input int items, input bit steady);
    logic [SENSOR_W-1:0] sensor;
    if (write_cfg) begin
      write_register(REG_MAX_DISTANCE, maxd);
      write_register(REG_FAR_MIN_SAMPLES, far_min);
      write_register(REG_FAR_REL_TOLERANCE, far_tol);
      write_register(REG_NEAR_MIN_SAMPLES, near_min);
      write_register(REG_NEAR_REL_TOLERANCE, near_tol);
      cfg_we <= 1'b0;
      @(negedge clk);
    end
    steady_run = steady;
    for (int s = 0; s < 16; s++) begin
      sensor_target[s] = ($urandom_range(0, 3) == 0) ? int'(cfg_max_distance)
                                                     : $urandom_range(1, 1023);
    end
    for (int n = 0; n < items; n++) begin
      sensor = pick_sensor();
      send_reading(sensor, pick_distance(sensor), 1'b0, '0);
    end
    reading_ch.valid <= 1'b0;
    steady_run = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Result side: random back-pressure, except in a steady run
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= steady_run || ($urandom_range(0, 99) >= 27);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    distance_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, sensor", result_ch.sensor_out, -1);
      end else begin
        want = expected_results.pop_front();
        if (result_ch.sensor_out !== want.sensor)
          report_mismatch("sensor_out", result_ch.sensor_out, want.sensor);
        if (result_ch.accepted_distance !== want.dist_cm)
          report_mismatch("accepted_distance", result_ch.accepted_distance, want.dist_cm);
        if (result_ch.took_new !== want.took)
          report_mismatch("took_new", result_ch.took_new, want.took);
      end
    end
  end

  // Directed items at the reset settings; typed rows are plain to read off
  initial begin
    directed_table[0]  = {4'd0,  10'd0,    1'b1, 4'd0,  10'd400, 1'b1};
    directed_table[1]  = {4'd15, 10'd1023, 1'b1, 4'd15, 10'd0,   1'b0};
    directed_table[2]  = {4'd12, 10'd1,    1'b1, 4'd12, 10'd0,   1'b0};
    directed_table[3]  = {4'd11, 10'd1,    1'b1, 4'd11, 10'd400, 1'b0};
    directed_table[4]  = {4'd1,  10'd400,  1'b1, 4'd1,  10'd400, 1'b1};
    // four far-off readings in a row: the fourth is finally believed
    directed_table[5]  = {4'd2,  10'd1023, 1'b0, 15'd0};
    directed_table[6]  = {4'd2,  10'd1023, 1'b0, 15'd0};
    directed_table[7]  = {4'd2,  10'd1023, 1'b0, 15'd0};
    directed_table[8]  = {4'd2,  10'd1023, 1'b0, 15'd0};
    // no echo twice: far count of two
    directed_table[9]  = {4'd2,  10'd0,    1'b0, 15'd0};
    directed_table[10] = {4'd2,  10'd0,    1'b0, 15'd0};
    directed_table[11] = {4'd3,  10'd390,  1'b0, 15'd0};
    directed_table[12] = {4'd3,  10'd512,  1'b0, 15'd0};
    directed_table[13] = {4'd4,  10'd511,  1'b0, 15'd0};
    directed_table[14] = {4'd4,  10'd1022, 1'b0, 15'd0};
    directed_table[15] = {4'd5,  10'd685,  1'b0, 15'd0};
    directed_table[16] = {4'd6,  10'd338,  1'b0, 15'd0};
    directed_table[17] = {4'd7,  10'd8,    1'b0, 15'd0};
    directed_table[18] = {4'd8,  10'd1023, 1'b0, 15'd0};
    directed_table[19] = {4'd9,  10'd0,    1'b0, 15'd0};
    directed_table[20] = {4'd10, 10'd2,    1'b0, 15'd0};
    directed_table[21] = {4'd13, 10'd0,    1'b1, 4'd13, 10'd0,   1'b0};
    directed_table[22] = {4'd14, 10'd512,  1'b1, 4'd14, 10'd0,   1'b0};
  end

  // Main sequence
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    reading_ch.valid         = 1'b0;
    reading_ch.sensor_number = '0;
    reading_ch.raw_distance  = '0;
    mismatches   = 0;
    steady_run   = 1'b0;
    focus_sensor = 0;
    clear_history();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_reading(directed_table[i].sensor, directed_table[i].raw,
                   directed_table[i].typed, directed_table[i].want);
    end
    reading_ch.valid <= 1'b0;
    @(negedge clk);

    // reset settings, then extremes, zero max distance, oversized counts, a middle setting, random
    run_phase(1'b0, 0, 0, 0, 0, 0, 150, 1'b0);
    run_phase(1'b1, 1023, 8, 255, 8, 255, 150, 1'b1);
    run_phase(1'b1, 1, 1, 0, 1, 0, 150, 1'b0);
    run_phase(1'b1, 0, 0, 0, 0, 0, 120, 1'b0);
    run_phase(1'b1, 400, 15, 13, 15, 26, 150, 1'b0);
    run_phase(1'b1, 200, 3, 40, 5, 20, 150, 1'b0);
    run_phase(1'b1, $urandom_range(1, 1023), $urandom_range(1, 8), $urandom_range(0, 255),
              $urandom_range(1, 8), $urandom_range(0, 255), 150, 1'b0);
    run_phase(1'b1, $urandom_range(1, 1023), $urandom_range(1, 8), $urandom_range(0, 255),
              $urandom_range(1, 8), $urandom_range(0, 255), 150, 1'b0);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dsv_pkg.sv
rtl/dsv_reading_if.sv
rtl/dsv_result_if.sv
rtl/distance_sample_validator_unit.sv
tb/sv/tb_distance_sample_validator_unit.sv
